@@ hw/rtl/pt2sv_pkg.sv @@
// Shared types and constants for the PT2 servo velocity model.
// No dependencies; compile first.
package pt2sv_pkg;

    localparam int DATA_W    = 32;               // Q16.16 signed words
    localparam int PAR_W     = 31;               // unsigned parameter registers
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W     = 48;               // dividend / quotient width
    localparam int DIV_STEPS = 2;                // quotient bits per cycle
    localparam int DIV_ITERS = DIV_W / DIV_STEPS;
    localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

    localparam logic [PAR_W-1:0]         RST_GAIN   = 31'd65536;
    localparam logic [PAR_W-1:0]         RST_DAMP   = 31'd65536;
    localparam logic [PAR_W-1:0]         RST_TCONST = 31'd65536;
    localparam logic [PAR_W-1:0]         RST_DT     = 31'd655;
    localparam logic [PAR_W-1:0]         RST_VLIM   = 31'd655360;
    localparam logic signed [DATA_W-1:0] RST_DMIN   = -32'sd205887;
    localparam logic signed [DATA_W-1:0] RST_DMAX   = 32'sd205887;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_DAMPING  = 3'd1,
        CFG_TCONST   = 3'd2,
        CFG_STEP     = 3'd3,
        CFG_VLIM     = 3'd4,
        CFG_LIM_EN   = 3'd5,
        CFG_DEFL_MIN = 3'd6,
        CFG_DEFL_MAX = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_TERM,
        ST_DIV_R,
        ST_MUL_R,
        ST_ACC,
        ST_DIV_V,
        ST_WAIT_V,
        ST_VEL,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_first;
        logic div_start_r;
        logic term;
        logic load_r;
        logic mul_r;
        logic acc;
        logic div_start_v;
        logic vel;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic filling;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/pt2sv_if.sv @@
// Channel interfaces for the PT2 servo velocity model (input and result words).
// Depends on pt2sv_pkg for field widths.
interface pt2sv_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  setpoint_valid;
    logic signed [pt2sv_pkg::DATA_W-1:0]   setpoint_request;
    logic signed [pt2sv_pkg::DATA_W-1:0]   measured_angle;

    modport source (output valid, output setpoint_valid, output setpoint_request,
                    output measured_angle, input ready);
    modport sink   (input valid, input setpoint_valid, input setpoint_request,
                    input measured_angle, output ready);
endinterface

interface pt2sv_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pt2sv_pkg::DATA_W-1:0]   velocity_command;

    modport source (output valid, output velocity_command, input ready);
    modport sink   (input valid, input velocity_command, output ready);
endinterface

@@ hw/rtl/pt2_servo_velocity_model.sv @@
// Top level of the PT2 servo velocity model: sequencer plus datapath.
// Depends on pt2sv_pkg, pt2sv_if, pt2sv_ctrl, pt2sv_dp.
//
// Usage:
//  - i_in carries one word per simulation tick: an optional new setpoint and
//    the measured angle. o_out carries the velocity command, Q16.16.
//  - The first DELAY_TICKS words after reset only fill the setpoint delay
//    line; they produce no result word.
//  - After that every word runs one lag step. The word is taken in the idle
//    cycle, the result shows on o_out after the multiply, divide, accumulate
//    and limit states, and the next word is taken in the cycle after the
//    result is loaded. The two divisions by the time constant dominate: each
//    runs in the shared two-bit-per-cycle divider.
//  - The result sits in an output register; the next word is accepted while
//    it waits. If the receiver still holds off when the following result is
//    ready, the sequencer waits in its final state until o_out drains.
//  - Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) are registered
//    directly and are meant for idle periods only.
//  - Synchronous active-low reset puts the config registers to their defaults,
//    clears the setpoint, the lag state and the fill count, and empties o_out.
module pt2_servo_velocity_model #(
    parameter int DELAY_TICKS = 2
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pt2sv_in_if.sink                         i_in,
    pt2sv_out_if.source                      o_out,
    input  logic                             i_cfg_we,
    input  logic [pt2sv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pt2sv_pkg::DATA_W-1:0]     i_cfg_data
);
    import pt2sv_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    pt2sv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pt2sv_dp #(
        .DELAY_TICKS (DELAY_TICKS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_setpoint_valid   (i_in.setpoint_valid),
        .i_setpoint_request (i_in.setpoint_request),
        .i_measured_angle   (i_in.measured_angle),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .o_out_valid        (o_out.valid),
        .i_out_ready        (o_out.ready),
        .o_velocity_command (o_out.velocity_command)
    );

    // input ready only while the sequencer is idle
    assign i_in.ready = w_in_ready;

endmodule

@@ hw/rtl/pt2sv_div.sv @@
// Sequential unsigned divider, two quotient bits per cycle.
// Depends on pt2sv_pkg.
module pt2sv_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pt2sv_pkg::DIV_W-1:0]    i_dividend,
    input  logic [pt2sv_pkg::PAR_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [pt2sv_pkg::DIV_W-1:0]    o_quotient
);
    import pt2sv_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PAR_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [PAR_W-1:0]     r_div;
    logic [PAR_W-1:0]     n_rem;
    logic [DIV_W-1:0]     n_quo;
    logic [PAR_W:0]       w_sh;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        w_sh  = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            w_sh  = {n_rem, n_quo[DIV_W-1]};
            n_quo = {n_quo[DIV_W-2:0], 1'b0};
            if (w_sh >= {1'b0, r_div}) begin
                w_sh     = w_sh - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = w_sh[PAR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_ITERS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> (r_busy && !r_done))
        else $error("divider start did not clear done");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider done while busy");

    a_last_iter_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !i_start && r_cnt == DIV_CNT_W'(1)) |=> r_done)
        else $error("divider missed completion");

endmodule

@@ hw/rtl/pt2sv_dp.sv @@
// Datapath: config registers, setpoint delay line, lag state and arithmetic.
// Depends on pt2sv_pkg and pt2sv_div.
module pt2sv_dp #(
    parameter int DELAY_TICKS = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pt2sv_pkg::t_cmd                      i_cmd,
    output pt2sv_pkg::t_status                   o_status,
    input  logic                                 i_setpoint_valid,
    input  logic signed [pt2sv_pkg::DATA_W-1:0]  i_setpoint_request,
    input  logic signed [pt2sv_pkg::DATA_W-1:0]  i_measured_angle,
    input  logic                                 i_cfg_we,
    input  logic [pt2sv_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pt2sv_pkg::DATA_W-1:0]         i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [pt2sv_pkg::DATA_W-1:0]  o_velocity_command
);
    import pt2sv_pkg::*;

    localparam int FILL_W = (DELAY_TICKS > 0) ? $clog2(DELAY_TICKS + 1) : 1;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DELAY_TICKS);
    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

    function automatic logic signed [DATA_W-1:0] sat51(input logic signed [50:0] v);
        if (!v[50] && (|v[49:31])) begin
            return S32_MAX;
        end else if (v[50] && !(&v[49:31])) begin
            return S32_MIN;
        end
        return v[31:0];
    endfunction

    // config
    logic [PAR_W-1:0]         r_gain, r_damp, r_tconst, r_dt, r_vlim;
    logic                     r_lim_en;
    logic signed [DATA_W-1:0] r_dmin, r_dmax;

    // state
    logic signed [DATA_W-1:0] r_held, n_held;
    logic [FILL_W-1:0]        r_fill;
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] w_sp_head;
    logic                     w_filling;

    // working registers
    logic signed [DATA_W-1:0] r_sp, r_y, r_term;
    logic signed [63:0]       r_pk, r_pd, r_pr;
    logic [PAR_W-1:0]         r_r;
    logic                     r_xneg;
    logic signed [48:0]       r_v;
    logic                     r_clip;
    logic [61:0]              r_pvt;
    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_vel;

    logic [PAR_W-1:0]         w_t;
    logic [DATA_W-1:0]        w_xabs;
    logic [DIV_W-1:0]         w_dividend, w_quo;
    logic                     w_div_done;
    logic signed [47:0]       w_ks, w_prs;
    logic signed [48:0]       w_ds, w_v;
    logic signed [50:0]       w_sum, w_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= RST_GAIN;
            r_damp   <= RST_DAMP;
            r_tconst <= RST_TCONST;
            r_dt     <= RST_DT;
            r_vlim   <= RST_VLIM;
            r_lim_en <= 1'b0;
            r_dmin   <= RST_DMIN;
            r_dmax   <= RST_DMAX;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN:     r_gain   <= i_cfg_data[PAR_W-1:0];
                CFG_DAMPING:  r_damp   <= i_cfg_data[PAR_W-1:0];
                CFG_TCONST:   r_tconst <= i_cfg_data[PAR_W-1:0];
                CFG_STEP:     r_dt     <= i_cfg_data[PAR_W-1:0];
                CFG_VLIM:     r_vlim   <= i_cfg_data[PAR_W-1:0];
                CFG_LIM_EN:   r_lim_en <= i_cfg_data[0];
                CFG_DEFL_MIN: r_dmin   <= i_cfg_data;
                CFG_DEFL_MAX: r_dmax   <= i_cfg_data;
            endcase
        end
    end

    // new setpoint, max test first
    always_comb begin
        n_held = r_held;
        if (i_setpoint_valid) begin
            if (!r_lim_en) begin
                n_held = i_setpoint_request;
            end else if (i_setpoint_request > r_dmax) begin
                n_held = r_dmax;
            end else if (i_setpoint_request < r_dmin) begin
                n_held = r_dmin;
            end else begin
                n_held = i_setpoint_request;
            end
        end
    end

    // delay line: shift in at the tail on every word, head is the delayed setpoint
    if (DELAY_TICKS > 0) begin : g_hist
        logic signed [DATA_W-1:0] r_hist [DELAY_TICKS];
        always_ff @(posedge i_clk) begin
            if (i_cmd.accept) begin
                for (int i = 0; i < DELAY_TICKS - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
                r_hist[DELAY_TICKS-1] <= n_held;
            end
        end
        assign w_sp_head = r_hist[0];
    end else begin : g_nohist
        assign w_sp_head = n_held;
    end

    assign w_filling = (r_fill < FILL_FULL);

    assign w_t      = (r_tconst == '0) ? PAR_W'(1) : r_tconst;
    assign w_xabs   = r_x[DATA_W-1] ? (32'd0 - r_x) : r_x;
    assign w_dividend = i_cmd.div_start_v ? {w_xabs, 16'd0} : {1'b0, r_dt, 16'd0};

    pt2sv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start_r | i_cmd.div_start_v),
        .i_dividend (w_dividend),
        .i_divisor  (w_t),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // floor shifts are plain part-selects of the signed products
    assign w_ks  = r_pk[63:16];
    assign w_ds  = r_pd[63:15];
    assign w_prs = r_pr[63:16];
    assign w_sum = $signed({{3{w_ks[47]}}, w_ks}) - $signed({{19{r_y[31]}}, r_y})
                 - $signed({{2{w_ds[48]}}, w_ds});
    assign w_acc = $signed({{19{r_x[31]}}, r_x}) + $signed({{3{w_prs[47]}}, w_prs});
    assign w_v   = r_xneg ? -$signed({1'b0, w_quo}) : $signed({1'b0, w_quo});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_fill      <= '0;
            r_x         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_held <= n_held;
                if (w_filling) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.acc) begin
                r_x <= sat51(w_acc);
            end else if (i_cmd.emit && r_clip) begin
                r_x <= (|r_pvt[61:47]) ? S32_MAX : {1'b0, r_pvt[46:16]};
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sp <= w_sp_head;
            r_y  <= i_measured_angle;
        end
        if (i_cmd.mul_first) begin
            r_pk <= $signed({1'b0, r_gain}) * r_sp;
            r_pd <= $signed({1'b0, r_damp}) * r_x;
        end
        if (i_cmd.term) begin
            r_term <= sat51(w_sum);
        end
        if (i_cmd.load_r) begin
            r_r <= (|w_quo[DIV_W-1:PAR_W]) ? {PAR_W{1'b1}} : w_quo[PAR_W-1:0];
        end
        if (i_cmd.mul_r) begin
            r_pr <= $signed({1'b0, r_r}) * r_term;
        end
        if (i_cmd.div_start_v) begin
            r_xneg <= r_x[DATA_W-1];
        end
        if (i_cmd.vel) begin
            r_v    <= w_v;
            r_clip <= (w_v > $signed({18'd0, r_vlim}));
            r_pvt  <= r_vlim * w_t;
        end
        if (i_cmd.emit) begin
            r_vel <= r_clip ? {1'b0, r_vlim} : sat51($signed({{2{r_v[48]}}, r_v}));
        end
    end

    assign o_status.filling  = w_filling;
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid        = r_out_valid;
    assign o_velocity_command = r_vel;

    a_emit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> r_out_valid)
        else $error("result word not presented after emit");

    a_clip_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && r_clip) |=> !r_x[DATA_W-1])
        else $error("lag state negative after velocity clip");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && w_filling) |=> (r_fill == FILL_W'($past(r_fill) + 1'b1)))
        else $error("fill count did not advance");

endmodule

@@ hw/rtl/pt2sv_ctrl.sv @@
// Sequencer for one lag step: multiply, divide, accumulate, limit, emit.
// Depends on pt2sv_pkg.
module pt2sv_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pt2sv_pkg::t_status  i_status,
    output pt2sv_pkg::t_cmd     o_cmd
);
    import pt2sv_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (!i_status.filling) begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_first   = 1'b1;
                o_cmd.div_start_r = 1'b1;
                n_state           = ST_TERM;
            end
            ST_TERM: begin
                o_cmd.term = 1'b1;
                n_state    = ST_DIV_R;
            end
            ST_DIV_R: begin
                if (i_status.div_done) begin
                    o_cmd.load_r = 1'b1;
                    n_state      = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                o_cmd.mul_r = 1'b1;
                n_state     = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = ST_DIV_V;
            end
            ST_DIV_V: begin
                o_cmd.div_start_v = 1'b1;
                n_state           = ST_WAIT_V;
            end
            ST_WAIT_V: begin
                if (i_status.div_done) begin
                    n_state = ST_VEL;
                end
            end
            ST_VEL: begin
                o_cmd.vel = 1'b1;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ sim/pt2sv_velocity_checker.sv @@
// Checker for the PT2 servo velocity model: watches the input, result and config ports,
// predicts each velocity command and compares it with the word on o_out.
// Depends on pt2sv_pkg and the channel interfaces in pt2sv_if.
module pt2sv_velocity_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pt2sv_in_if                              in_ch,
    pt2sv_out_if                             out_ch,
    input  logic                             i_cfg_we,
    input  logic [pt2sv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pt2sv_pkg::DATA_W-1:0]     i_cfg_data,
    output int                               o_errors,
    output int                               o_pending
);
    import pt2sv_pkg::*;

    localparam int LAG_DELAY = 2;

    // shadow copy of the register file
    logic [PAR_W-1:0]         gain_k, damp_d, tconst_t, step_dt, vel_lim;
    logic                     clamp_en;
    logic signed [DATA_W-1:0] defl_lo, defl_hi;

    // shadow copy of the lag state
    logic signed [DATA_W-1:0] held_sp;
    logic signed [DATA_W-1:0] sp_line [LAG_DELAY];
    int                       line_fill;
    logic signed [DATA_W-1:0] lag_x;

    logic signed [DATA_W-1:0] vel_expected [$];

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[DATA_W-1:0];
    endfunction

    // one tick of the servo; returns 1 when a velocity word comes out
    function automatic bit run_tick(input logic sp_new, input logic signed [DATA_W-1:0] req,
                                    input logic signed [DATA_W-1:0] ang,
                                    output logic signed [DATA_W-1:0] vel);
        logic signed [DATA_W-1:0] sp;
        logic signed [DATA_W-1:0] want;
        longint t_div, rate, term, v;
        want = req;
        vel  = '0;
        if (sp_new) begin
            if (clamp_en) begin
                if (want > defl_hi)
                    want = defl_hi;
                else if (want < defl_lo)
                    want = defl_lo;
            end
            held_sp = want;
        end
        if (line_fill < LAG_DELAY) begin
            sp_line[line_fill] = held_sp;
            line_fill++;
            return 1'b0;
        end
        sp = sp_line[0];
        for (int i = 0; i + 1 < LAG_DELAY; i++)
            sp_line[i] = sp_line[i+1];
        sp_line[LAG_DELAY-1] = held_sp;

        t_div = (tconst_t == '0) ? 64'sd1 : longint'(tconst_t);
        rate  = (longint'(step_dt) * 65536) / t_div;
        if (rate > 64'sd2147483647)
            rate = 64'sd2147483647;
        term = ((longint'(gain_k) * longint'(sp)) >>> 16) - longint'(ang)
             - ((longint'(damp_d) * longint'(lag_x)) >>> 15);
        term  = longint'(clamp32(term));
        lag_x = clamp32(longint'(lag_x) + ((rate * term) >>> 16));
        v = (longint'(lag_x) * 65536) / t_div;
        if (v > longint'(vel_lim)) begin
            vel   = {1'b0, vel_lim};
            lag_x = clamp32((longint'(vel_lim) * t_div) >>> 16);
        end else begin
            vel = clamp32(v);
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        logic signed [DATA_W-1:0] vel_pred;
        logic signed [DATA_W-1:0] vel_want;
        if (!i_rst_n) begin
            gain_k    = RST_GAIN;
            damp_d    = RST_DAMP;
            tconst_t  = RST_TCONST;
            step_dt   = RST_DT;
            vel_lim   = RST_VLIM;
            clamp_en  = 1'b0;
            defl_lo   = RST_DMIN;
            defl_hi   = RST_DMAX;
            held_sp   = '0;
            line_fill = 0;
            lag_x     = '0;
            for (int i = 0; i < LAG_DELAY; i++)
                sp_line[i] = '0;
            vel_expected.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GAIN:     gain_k   = i_cfg_data[PAR_W-1:0];
                    CFG_DAMPING:  damp_d   = i_cfg_data[PAR_W-1:0];
                    CFG_TCONST:   tconst_t = i_cfg_data[PAR_W-1:0];
                    CFG_STEP:     step_dt  = i_cfg_data[PAR_W-1:0];
                    CFG_VLIM:     vel_lim  = i_cfg_data[PAR_W-1:0];
                    CFG_LIM_EN:   clamp_en = i_cfg_data[0];
                    CFG_DEFL_MIN: defl_lo  = i_cfg_data;
                    CFG_DEFL_MAX: defl_hi  = i_cfg_data;
                    default: ;
                endcase
            end
            // result side first: a word leaving now belongs to an older input
            if (out_ch.valid && out_ch.ready) begin
                if (vel_expected.size() == 0) begin
                    $display("%0t: unexpected velocity word, expected none, got %0d",
                             $time, out_ch.velocity_command);
                    o_errors <= o_errors + 1;
                end else begin
                    vel_want = vel_expected[0];
                    vel_expected.delete(0);
                    if (out_ch.velocity_command !== vel_want) begin
                        $display("%0t: velocity_command mismatch, expected %0d, got %0d",
                                 $time, vel_want, out_ch.velocity_command);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                if (run_tick(in_ch.setpoint_valid, in_ch.setpoint_request,
                             in_ch.measured_angle, vel_pred))
                    vel_expected.insert(vel_expected.size(), vel_pred);
            end
        end
        o_pending <= vel_expected.size();
    end

endmodule

@@ sim/pt2_servo_velocity_model_test.sv @@
// Testbench top for the PT2 servo velocity model: clock, reset, stimulus and verdict.
// Depends on pt2sv_pkg, pt2sv_if, the block itself and pt2sv_velocity_checker.
module pt2_servo_velocity_model_test;
    import pt2sv_pkg::*;

    // ~1850 words at one lag step each, plus gaps and stalls, stays far below this
    localparam int LIMIT_CYCLES = 2000000;
    // quiet time after the last result before a register write or the verdict
    localparam int DRAIN_CYCLES = 80;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_WORDS  = 150;

    typedef struct {
        logic [PAR_W-1:0]         gain;
        logic [PAR_W-1:0]         damping;
        logic [PAR_W-1:0]         tconst;
        logic [PAR_W-1:0]         step;
        logic [PAR_W-1:0]         vlim;
        logic                     lim_en;
        logic signed [DATA_W-1:0] dmin;
        logic signed [DATA_W-1:0] dmax;
    } t_servo_cfg;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DATA_W-1:0]   cfg_data;
    int                  chk_errors;
    int                  chk_pending;
    int                  cycle_cnt = 0;
    bit                  calm;       // no idling on either side near the end
    int                  stall_left = 0;

    pt2sv_in_if  in_ch ();
    pt2sv_out_if out_ch ();

    pt2_servo_velocity_model u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pt2sv_velocity_checker u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: a hung handshake ends the run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver: random hold-off bursts, none once calm
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left   <= $urandom_range(0, 4);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // one input word; returns at the edge where it was taken, valid still high
    task automatic send_word(input logic sp_new, input logic signed [DATA_W-1:0] req,
                             input logic signed [DATA_W-1:0] ang);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid            <= 1'b1;
        in_ch.setpoint_valid   <= sp_new;
        in_ch.setpoint_request <= req;
        in_ch.measured_angle   <= ang;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
    endtask

    // stop sending, let every expected word arrive, then give the sequencer
    // time to fall back to idle (fill words leave no result to wait for)
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    // all eight registers back to back; bit 31 of the narrow ones is junk on purpose
    task automatic load_config(input t_servo_cfg c);
        put_reg(CFG_GAIN,     {1'($urandom_range(0, 1)), c.gain});
        put_reg(CFG_DAMPING,  {1'($urandom_range(0, 1)), c.damping});
        put_reg(CFG_TCONST,   {1'($urandom_range(0, 1)), c.tconst});
        put_reg(CFG_STEP,     {1'($urandom_range(0, 1)), c.step});
        put_reg(CFG_VLIM,     {1'($urandom_range(0, 1)), c.vlim});
        put_reg(CFG_LIM_EN,   {31'($urandom), c.lim_en});
        put_reg(CFG_DEFL_MIN, c.dmin);
        put_reg(CFG_DEFL_MAX, c.dmax);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_angle();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return $signed($urandom_range(0, 600000)) - 300000;
    endfunction

    // mostly plausible servo settings, now and then a raw 31-bit value
    function automatic t_servo_cfg pick_config();
        t_servo_cfg c;
        int sel;
        sel = $urandom_range(0, 9);
        c.tconst  = (sel == 0) ? 31'($urandom) :
                    (sel == 1) ? 31'd0 :
                    (sel == 2) ? 31'd1 : 31'($urandom_range(1024, 262144));
        c.gain    = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 196608));
        c.damping = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 131072));
        c.step    = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 6553));
        c.vlim    = ($urandom_range(0, 5) == 0) ? 31'($urandom) : 31'($urandom_range(0, 2097152));
        c.lim_en  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 5) == 0) begin
            c.dmin = $urandom;
            c.dmax = $urandom;
        end else begin
            c.dmin = -$signed($urandom_range(0, 300000));
            c.dmax = $signed($urandom_range(0, 300000));
        end
        return c;
    endfunction

    initial begin
        t_servo_cfg cfg;
        logic signed [DATA_W-1:0] sp_req;
        logic signed [DATA_W-1:0] ang;

        // every input known from time zero; o_out ready follows at the first edge
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = '0;
        cfg_data               = '0;
        calm                   = 1'b0;
        in_ch.valid            = 1'b0;
        in_ch.setpoint_valid   = 1'b0;
        in_ch.setpoint_request = '0;
        in_ch.measured_angle   = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed, reset settings ---
        // first two words only fill the setpoint delay line
        send_word(1'b1, 32'sh7FFFFFFF, 32'sd0);
        send_word(1'b0, 32'sd0,        32'sh80000000);
        send_word(1'b1, 32'sh80000000, 32'sh7FFFFFFF);
        send_word(1'b1, 32'sd65536,    32'sd0);
        send_word(1'b0, -32'sd1,       -32'sd1);
        send_word(1'b1, 32'sh7FFFFFFF, 32'sh80000000);
        send_word(1'b0, 32'sd0,        32'sd0);
        drain();

        // zero time constant, saturated step ratio, zero velocity limit, clamp on
        cfg = '{gain: 31'h7FFFFFFF, damping: 31'd0, tconst: 31'd0, step: 31'h7FFFFFFF,
                vlim: 31'd0, lim_en: 1'b1, dmin: -32'sd1000, dmax: 32'sd1000};
        load_config(cfg);
        send_word(1'b1, 32'sd5000,     32'sh80000000);
        send_word(1'b1, -32'sd5000,    32'sh7FFFFFFF);
        send_word(1'b1, 32'sd200,      32'sd0);
        send_word(1'b0, 32'sh7FFFFFFF, -32'sd100000);
        drain();

        // inverted deflection range: the upper bound wins first
        cfg = '{gain: 31'd65536, damping: 31'h7FFFFFFF, tconst: 31'h7FFFFFFF, step: 31'd0,
                vlim: 31'h7FFFFFFF, lim_en: 1'b1, dmin: 32'sd5000, dmax: -32'sd5000};
        load_config(cfg);
        send_word(1'b1, 32'sd6000,  32'sd0);
        send_word(1'b1, -32'sd6000, 32'sd0);
        send_word(1'b1, 32'sd0,     32'sd12345);
        send_word(1'b1, -32'sd5000, -32'sd777);
        drain();

        // large step and small limit: velocity clips and the lag state is rewound
        cfg = '{gain: 31'd65536, damping: 31'd32768, tconst: 31'd65536, step: 31'd65536,
                vlim: 31'd100, lim_en: 1'b0, dmin: 32'sh80000000, dmax: 32'sh7FFFFFFF};
        load_config(cfg);
        send_word(1'b1, 32'sd1000000, 32'sd0);
        send_word(1'b0, 32'sd0,       32'sd0);
        send_word(1'b0, 32'sd0,       -32'sd65536);
        send_word(1'b1, -32'sd1000000, 32'sd0);
        drain();

        // --- random phases, each with fresh settings ---
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph >= RAND_PHASES - 2)
                calm = 1'b1;
            load_config(pick_config());
            for (int n = 0; n < PHASE_WORDS; n++) begin
                sp_req = pick_angle();
                // usually the measured angle hovers around the request
                if ($urandom_range(0, 2) != 0)
                    ang = sp_req + ($signed($urandom_range(0, 8192)) - 4096);
                else
                    ang = pick_angle();
                send_word($urandom_range(0, 2) == 0, sp_req, ang);
            end
            drain();
        end

        if (chk_errors == 0 && chk_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
